// ===== hdl/quadrature_encoder_accel_counter_macros.svh =====
// assertion macros for the quadrature encoder counter
// used by the top level; expects clk and rst_n in scope
`ifndef QUADRATURE_ENCODER_ACCEL_COUNTER_MACROS_SVH
`define QUADRATURE_ENCODER_ACCEL_COUNTER_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define QEAC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qeac assertion failed");
// next-cycle implication
`define QEAC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qeac assertion failed");
`else
`define QEAC_ASSERT_IMP(lbl, ante, cons)
`define QEAC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/qeac_pkg.sv =====
// shared types, widths and constants of the quadrature encoder counter
// no dependencies
`timescale 1ns / 1ps

package qeac_pkg;

    localparam int NUM_ENCODERS_DEF = 8;
    localparam int ACCEL_SHIFT_DEF  = 4;

    localparam int ID_W       = 3;
    localparam int PINS_W     = 2;
    localparam int ACCEL_W    = 8;
    localparam int COUNT_W    = 18;
    localparam int VALUE_W    = 14;
    localparam int PPD_W      = 5;
    localparam int SUM_W      = 20;
    localparam int STEP_W     = ACCEL_W + 1;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_MIN_POS = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAX_POS = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_PPD     = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_INC     = 2'd3;

    localparam logic signed [VALUE_W-1:0] MIN_POS_RST = 14'sd0;
    localparam logic signed [VALUE_W-1:0] MAX_POS_RST = 14'sd127;
    localparam logic [PPD_W-1:0]          PPD_RST     = 5'd4;
    localparam logic [ACCEL_W-1:0]        INC_RST     = 8'd20;

    localparam logic [PPD_W-1:0]   PPD_MAX   = 5'd16;
    localparam logic [ACCEL_W-1:0] ACCEL_MAX = 8'd255;

    localparam logic signed [1:0] DIR_NONE = 2'sd0;
    localparam logic signed [1:0] DIR_FWD  = 2'sd1;
    localparam logic signed [1:0] DIR_BACK = -2'sd1;

    // indexed by {old B, old A, new B, new A}
    localparam logic signed [1:0] QUAD_TABLE [16] = '{
        DIR_NONE, DIR_BACK, DIR_FWD,  DIR_NONE,
        DIR_FWD,  DIR_NONE, DIR_NONE, DIR_BACK,
        DIR_BACK, DIR_NONE, DIR_NONE, DIR_FWD,
        DIR_NONE, DIR_FWD,  DIR_BACK, DIR_NONE
    };

    typedef struct packed {
        logic [PINS_W-1:0]         prev_pins;
        logic [ACCEL_W-1:0]        accel;
        logic signed [COUNT_W-1:0] count;
        logic signed [VALUE_W-1:0] last_value;
    } state_entry_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] min_pos;
        logic signed [VALUE_W-1:0] max_pos;
        logic [PPD_W-1:0]          ppd_eff;
        logic [ACCEL_W-1:0]        inc;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== hdl/qeac_regs.sv =====
// configuration registers on an apb-style port
// depends on qeac_pkg
`timescale 1ns / 1ps

module qeac_regs
    import qeac_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic signed [VALUE_W-1:0] min_pos_reg;
    logic signed [VALUE_W-1:0] max_pos_reg;
    logic [PPD_W-1:0]          ppd_reg;
    logic [ACCEL_W-1:0]        inc_reg;
    logic [REG_IDX_W-1:0]      reg_idx;
    logic                      wr_beat;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_beat = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_pos_reg <= MIN_POS_RST;
            max_pos_reg <= MAX_POS_RST;
            ppd_reg     <= PPD_RST;
            inc_reg     <= INC_RST;
        end
        else if (wr_beat)
        begin
            unique case (reg_idx)
                REG_MIN_POS: min_pos_reg <= $signed(pwdata[VALUE_W-1:0]);
                REG_MAX_POS: max_pos_reg <= $signed(pwdata[VALUE_W-1:0]);
                REG_PPD:     ppd_reg     <= pwdata[PPD_W-1:0];
                REG_INC:     inc_reg     <= pwdata[ACCEL_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MIN_POS: prdata = APB_DATA_W'(min_pos_reg);
            REG_MAX_POS: prdata = APB_DATA_W'(max_pos_reg);
            REG_PPD:     prdata = APB_DATA_W'(ppd_reg);
            REG_INC:     prdata = APB_DATA_W'(inc_reg);
        endcase
    end

    // zero counts as one, anything above sixteen as sixteen
    always_comb
    begin
        cfg.min_pos = min_pos_reg;
        cfg.max_pos = max_pos_reg;
        cfg.inc     = inc_reg;
        if (ppd_reg == '0)
            cfg.ppd_eff = PPD_W'(1);
        else if (ppd_reg > PPD_MAX)
            cfg.ppd_eff = PPD_MAX;
        else
            cfg.ppd_eff = ppd_reg;
    end

endmodule

// ===== hdl/qeac_state_mem.sv =====
// per-encoder state memory, one read and one write port, registered read
// depends on qeac_pkg; unwritten entries read as zero
`timescale 1ns / 1ps

module qeac_state_mem
    import qeac_pkg::*;
#(
    parameter int DEPTH  = NUM_ENCODERS_DEF,
    parameter int ADDR_W = 3
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output state_entry_t      rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  state_entry_t      wr_data
);

    state_entry_t     mem_reg [DEPTH];
    state_entry_t     rd_data_reg;
    logic [DEPTH-1:0] valid_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem_reg[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
            if (rd_en)
                rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== hdl/qeac_div.sv =====
// serial signed divider, one quotient bit per cycle, truncates toward zero
// depends on qeac_pkg; divisor must be 1 to 16
`timescale 1ns / 1ps

module qeac_div
    import qeac_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [COUNT_W-1:0] dividend,
    input  logic [PPD_W-1:0]          divisor,
    output div_stat_t                 stat,
    output logic signed [VALUE_W-1:0] quotient
);

    localparam int ITER_W = $clog2(COUNT_W + 1);
    localparam int REM_W  = PPD_W - 1;

    logic              busy_reg;
    logic              done_reg;
    logic [ITER_W-1:0] iter_reg;
    logic [COUNT_W-1:0] q_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [PPD_W-1:0]  div_reg;
    logic              neg_reg;

    logic [PPD_W-1:0]   rem_shift;
    logic               fits;
    logic [PPD_W-1:0]   rem_sub;
    logic [VALUE_W-1:0] mag;

    assign rem_shift = {rem_reg, q_reg[COUNT_W-1]};
    assign fits      = rem_shift >= div_reg;
    assign rem_sub   = fits ? (rem_shift - div_reg) : rem_shift;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= ITER_W'(COUNT_W);
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg - ITER_W'(1);
                if (iter_reg == ITER_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // magnitude is shifted out msb first while quotient bits enter at the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend[COUNT_W-1] ? COUNT_W'(-dividend) : COUNT_W'(dividend);
            rem_reg <= '0;
            div_reg <= divisor;
            neg_reg <= dividend[COUNT_W-1];
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[COUNT_W-2:0], fits};
            rem_reg <= rem_sub[REM_W-1:0];
        end
    end

    assign mag       = q_reg[VALUE_W-1:0];
    assign quotient  = neg_reg ? $signed(-mag) : $signed(mag);
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== hdl/quadrature_encoder_accel_counter.sv =====
// top level of the multi-encoder quadrature counter with acceleration
// depends on qeac_pkg, qeac_regs, qeac_state_mem, qeac_div and the macro header
`timescale 1ns / 1ps
`include "quadrature_encoder_accel_counter_macros.svh"

// usage
// input channel (in_valid/in_ready): one beat is a sampled pin pair of one encoder.
// output channel (out_valid/out_ready): one beat per input beat, in order, with
// the encoder's reported value, a changed flag and the decoded step direction.
// config registers sit on the apb-style port at byte addresses 0, 4, 8 and 12:
// min position, max position, pulses per detent, acceleration increment.
// per-encoder state lives in a single memory; one sample is handled at a time.
// a sample that steps passes through load, sum, clamp, the serial divide by pulses
// per detent and finish before the next sample is taken; a sample without a step
// goes from load straight to finish, and an encoder id beyond the range goes from
// idle straight to finish.
// a result sits in the output register while the next sample is worked on; if
// the receiver still stalls when that one finishes, the block holds it there.
// reset brings every encoder to zero position and zero level, and the
// registers to their defaults; no clearing pass is needed.
module quadrature_encoder_accel_counter
    import qeac_pkg::*;
#(
    parameter int NUM_ENCODERS = NUM_ENCODERS_DEF,
    parameter int ACCEL_SHIFT  = ACCEL_SHIFT_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0]     pwdata,
    output logic [APB_DATA_W-1:0]     prdata,
    output logic                      pready,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [ID_W-1:0]           encoder_id,
    input  logic                      pin_a_level,
    input  logic                      pin_b_level,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [ID_W-1:0]           encoder_id_out,
    output logic signed [VALUE_W-1:0] position_value,
    output logic                      value_changed,
    output logic signed [1:0]         step_direction
);

    localparam int ADDR_W = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LOAD  = 6'b000010,
        S_SUM   = 6'b000100,
        S_CLAMP = 6'b001000,
        S_DIV   = 6'b010000,
        S_FIN   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    cfg_t         cfg;
    div_stat_t    div_stat;
    state_entry_t mem_rd_data;
    state_entry_t mem_wr_data;
    logic         mem_wr_en;

    logic [ID_W-1:0]           id_reg;
    logic [PINS_W-1:0]         pins_reg;
    logic                      in_range_reg;
    state_entry_t              entry_reg;
    logic signed [1:0]         dir_reg;
    logic [ACCEL_W-1:0]        lvl_reg;
    logic signed [SUM_W-1:0]   lo_reg;
    logic signed [SUM_W-1:0]   hi_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [COUNT_W-1:0] cnt_reg;

    logic                      out_valid_reg;
    logic [ID_W-1:0]           out_id_reg;
    logic signed [VALUE_W-1:0] out_pos_reg;
    logic                      out_chg_reg;
    logic signed [1:0]         out_dir_reg;

    logic                      accept;
    logic                      in_range;
    logic                      out_free;
    logic [PINS_W-1:0]         pins_in;
    logic signed [1:0]         dir_load;
    logic [ACCEL_W-1:0]        lvl_dec;
    logic [STEP_W-1:0]         lvl_sum;
    logic [ACCEL_W-1:0]        lvl_load;
    logic signed [SUM_W-1:0]   min_ext;
    logic signed [SUM_W-1:0]   max_ext;
    logic signed [SUM_W-1:0]   ppd_ext;
    logic [STEP_W-1:0]         step_size;
    logic signed [SUM_W-1:0]   step_ext;
    logic signed [SUM_W-1:0]   count_ext;
    logic signed [SUM_W-1:0]   sum_calc;
    logic signed [SUM_W-1:0]   clamp_lo;
    logic signed [SUM_W-1:0]   clamp_hi;
    logic signed [VALUE_W-1:0] quotient;
    logic                      stepped;
    logic signed [COUNT_W-1:0] new_count;
    logic signed [VALUE_W-1:0] new_last;
    logic                      changed;

    qeac_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    qeac_state_mem #(
        .DEPTH  (NUM_ENCODERS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept && in_range),
        .rd_addr (ADDR_W'(encoder_id)),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (ADDR_W'(id_reg)),
        .wr_data (mem_wr_data)
    );

    qeac_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_CLAMP),
        .dividend (clamp_hi[COUNT_W-1:0]),
        .divisor  (cfg.ppd_eff),
        .stat     (div_stat),
        .quotient (quotient)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign in_range = int'(encoder_id) < NUM_ENCODERS;
    assign out_free = !out_valid_reg || out_ready;
    assign pins_in  = {pin_b_level, pin_a_level};

    // decode and level update from the freshly read entry, clamp bounds from the config
    assign dir_load = QUAD_TABLE[{mem_rd_data.prev_pins, pins_reg}];
    assign lvl_dec  = mem_rd_data.accel - ACCEL_W'(mem_rd_data.accel != '0);
    assign lvl_sum  = {1'b0, lvl_dec} + {1'b0, cfg.inc};
    assign lvl_load = (dir_load == DIR_NONE) ? lvl_dec
                    : (lvl_sum[ACCEL_W] ? ACCEL_MAX : lvl_sum[ACCEL_W-1:0]);
    assign min_ext  = SUM_W'(cfg.min_pos);
    assign max_ext  = SUM_W'(cfg.max_pos);
    assign ppd_ext  = $signed(SUM_W'(cfg.ppd_eff));

    assign step_size = STEP_W'(lvl_reg >> ACCEL_SHIFT) + STEP_W'(1);
    assign step_ext  = $signed(SUM_W'(step_size));
    assign count_ext = SUM_W'(entry_reg.count);
    assign sum_calc  = (dir_reg == DIR_FWD) ? (count_ext + step_ext) : (count_ext - step_ext);

    // lower bound first, upper bound wins when they cross
    assign clamp_lo = (sum_reg < lo_reg) ? lo_reg : sum_reg;
    assign clamp_hi = (clamp_lo > hi_reg) ? hi_reg : clamp_lo;

    assign stepped   = (dir_reg != DIR_NONE);
    assign new_count = stepped ? cnt_reg : entry_reg.count;
    assign new_last  = stepped ? quotient : entry_reg.last_value;
    assign changed   = stepped && (quotient != entry_reg.last_value);

    assign mem_wr_en              = (state_reg == S_FIN) && out_free && in_range_reg;
    assign mem_wr_data.prev_pins  = pins_reg;
    assign mem_wr_data.accel      = lvl_reg;
    assign mem_wr_data.count      = new_count;
    assign mem_wr_data.last_value = new_last;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = in_range ? S_LOAD : S_FIN;
            end
            S_LOAD:
            begin
                state_next = (dir_load == DIR_NONE) ? S_FIN : S_SUM;
            end
            S_SUM:
            begin
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_stat.done)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_FIN) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            id_reg       <= encoder_id;
            pins_reg     <= pins_in;
            in_range_reg <= in_range;
            dir_reg      <= DIR_NONE;
        end
        if (state_reg == S_LOAD)
        begin
            entry_reg <= mem_rd_data;
            dir_reg   <= dir_load;
            lvl_reg   <= lvl_load;
            lo_reg    <= min_ext * ppd_ext;
            hi_reg    <= max_ext * ppd_ext;
        end
        if (state_reg == S_SUM)
            sum_reg <= sum_calc;
        if (state_reg == S_CLAMP)
            cnt_reg <= clamp_hi[COUNT_W-1:0];
        if ((state_reg == S_FIN) && out_free)
        begin
            out_id_reg  <= id_reg;
            out_pos_reg <= in_range_reg ? new_last : '0;
            out_chg_reg <= in_range_reg && changed;
            out_dir_reg <= in_range_reg ? dir_reg : DIR_NONE;
        end
    end

    assign out_valid      = out_valid_reg;
    assign encoder_id_out = out_id_reg;
    assign position_value = out_pos_reg;
    assign value_changed  = out_chg_reg;
    assign step_direction = out_dir_reg;

    `QEAC_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready)
    `QEAC_ASSERT_IMP(a_change_needs_step, out_valid && value_changed, step_direction != DIR_NONE)
    `QEAC_ASSERT_IMP(a_foreign_id_quiet, out_valid && (int'(encoder_id_out) >= NUM_ENCODERS), !value_changed && (step_direction == DIR_NONE) && (position_value == '0))
    `QEAC_ASSERT_IMP(a_div_in_div_state, div_stat.busy, state_reg == S_DIV)

endmodule
